>>> hw/rtl/iir_third_order_filter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the third-order IIR filter top level
// Each macro places one labeled concurrent assertion on the rising clock edge,
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef IIR_THIRD_ORDER_FILTER_TOP_ASSERT_SVH
`define IIR_THIRD_ORDER_FILTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IIR3_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IIR3_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/iir3_pkg.sv
// ----------------------------------------------------------------------------
// iir3_pkg
// Widths, register indexes, constants and control types shared by the filter.
// ----------------------------------------------------------------------------
package iir3_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int COEFF_W     = 32;
   localparam int PROD_W      = SAMPLE_W + COEFF_W;
   // Seven products of at most 2^62 each stay below 2^65 in magnitude.
   localparam int ACC_W       = PROD_W + 3;
   localparam int COEFF_NUM   = 4;
   localparam int TAP_W       = 2;
   localparam int CSR_INDEX_W = 4;
   localparam int FRAC_SHIFT  = 28;
   // Quotient bits produced by the serial divider.
   localparam int DIV_STEPS   = 31;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEFF_W-1:0]  coeff_type;

   localparam logic [CSR_INDEX_W-1:0] NUM_COEFF_BASE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] DEN_COEFF_BASE = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT      = 4'd8;

   localparam coeff_type  COEFF_ONE  = 32'sh1000_0000;
   localparam sample_type SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam sample_type SAMPLE_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic             capture;
      logic             mul_en;
      logic [TAP_W-1:0] tap;
      logic             is_den;
      logic             mag;
      logic             check;
      logic             div_step;
      logic             finish;
   } dp_cmd_type;

   typedef struct packed {
      logic skip_div;
      logic out_free;
   } dp_status_type;

endpackage

>>> hw/rtl/iir3_interfaces.sv
// ----------------------------------------------------------------------------
// iir3 channel interfaces
// Valid/ready channels for input samples, output samples and register writes.
// ----------------------------------------------------------------------------
interface iir3_req_if import iir3_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type actuation_sample;

   modport source (output valid, output actuation_sample, input ready);
   modport sink   (input valid, input actuation_sample, output ready);
endinterface

interface iir3_rsp_if import iir3_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type response_sample;

   modport source (output valid, output response_sample, input ready);
   modport sink   (input valid, input response_sample, output ready);
endinterface

interface iir3_csr_if import iir3_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [COEFF_W-1:0]     wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> hw/rtl/iir3_ctrl.sv
// ----------------------------------------------------------------------------
// iir3_ctrl
// Sequencer: multiply-accumulate steps, magnitude and range check, serial
// divide and result hand-off.
// ----------------------------------------------------------------------------
module iir3_ctrl import iir3_pkg::*; #(
   parameter int NUM_TAPS = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int MAC_LAST = 2 * NUM_TAPS - 2;
   localparam int DIV_LAST = DIV_STEPS - 1;
   localparam int CNT_MAX  = (MAC_LAST > DIV_LAST) ? MAC_LAST : DIV_LAST;
   localparam int CNT_W    = $clog2(CNT_MAX + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_MAG,
      ST_CHECK,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] step_plus;

   assign step_plus = cnt_ff + CNT_W'(1);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd        = '0;
      // Step zero is b0*x; odd steps take b_i, even steps a_i, for tap (step+1)/2.
      cmd.tap    = step_plus[TAP_W:1];
      cmd.is_den = (cnt_ff != '0) && !cnt_ff[0];
      case (state_ff)
         ST_IDLE:   cmd.capture  = req_valid;
         ST_MAC:    cmd.mul_en   = 1'b1;
         ST_MAG:    cmd.mag      = 1'b1;
         ST_CHECK:  cmd.check    = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_FINISH: cmd.finish   = 1'b1;
         default:   cmd          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_MAC;
                  cnt_ff   <= '0;
               end
            end
            ST_MAC: begin
               if (cnt_ff == CNT_W'(MAC_LAST)) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  cnt_ff <= step_plus;
               end
            end
            ST_DRAIN: state_ff <= ST_MAG;
            ST_MAG:   state_ff <= ST_CHECK;
            ST_CHECK: begin
               cnt_ff   <= '0;
               state_ff <= status.skip_div ? ST_FINISH : ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff == CNT_W'(DIV_LAST)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  cnt_ff <= step_plus;
               end
            end
            ST_FINISH: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> hw/rtl/iir3_datapath.sv
// ----------------------------------------------------------------------------
// iir3_datapath
// Coefficient registers, sample histories, shared multiplier, accumulator,
// restoring divider and output register.
// ----------------------------------------------------------------------------
module iir3_datapath import iir3_pkg::*; #(
   parameter int NUM_TAPS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEFF_W-1:0]     csr_wdata,
   input  sample_type             req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sample_type             rsp_sample
);

   localparam int HIST_LEN   = NUM_TAPS - 1;
   localparam int HIST_IDX_W = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
   localparam int SH_W       = ACC_W - FRAC_SHIFT;
   localparam int QUO_W      = DIV_STEPS;

   coeff_type  num_ff [COEFF_NUM];
   coeff_type  den_ff [COEFF_NUM];
   sample_type xh_ff  [HIST_LEN];
   sample_type yh_ff  [HIST_LEN];
   sample_type x_ff;

   coeff_type             coef_sel;
   sample_type            samp_sel;
   logic [HIST_IDX_W-1:0] hist_idx;
   logic [TAP_W-1:0]      tap_less;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_sub_ff;
   logic                     prod_valid_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic [ACC_W-1:0]        mag_ff, mag_in;
   logic [COEFF_W-1:0]      d_ff, d_in;
   logic                    neg_res_ff;
   logic signed [SH_W-1:0]  sh_val;
   sample_type              shy_ff, shy_in;

   logic                    div_zero;
   logic                    ovf;
   logic                    use_div_ff;
   sample_type              y_ff;
   logic [COEFF_W-1:0]      rem_ff, rem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [COEFF_W:0]        trial;
   logic                    trial_ge;

   sample_type              q_s;
   sample_type              y_fin;
   logic                    rsp_valid_ff;
   sample_type              rsp_sample_ff;
   logic                    fire;

   // Register writes beyond the coefficient list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k < COEFF_NUM; k++) begin
            num_ff[k] <= '0;
            den_ff[k] <= '0;
         end
         num_ff[0] <= COEFF_ONE;
         den_ff[0] <= COEFF_ONE;
      end else if (csr_valid) begin
         if (csr_index < DEN_COEFF_BASE) begin
            num_ff[csr_index[TAP_W-1:0]] <= csr_wdata;
         end else if (csr_index < CSR_COUNT) begin
            den_ff[csr_index[TAP_W-1:0]] <= csr_wdata;
         end
      end
   end

   // Operand selection for the shared multiplier.
   assign tap_less = cmd.tap - TAP_W'(1);
   assign hist_idx = tap_less[HIST_IDX_W-1:0];
   assign coef_sel = cmd.is_den ? den_ff[cmd.tap] : num_ff[cmd.tap];
   assign samp_sel = (cmd.tap == '0) ? x_ff
                   : (cmd.is_den ? yh_ff[hist_idx] : xh_ff[hist_idx]);
   assign prod_in  = coef_sel * samp_sel;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.capture) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = prod_sub_ff ? acc_ff - ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      end
   end

   // Magnitude, divisor and shift-path result, taken from the finished sum.
   assign mag_in = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign d_in   = den_ff[0][COEFF_W-1] ? COEFF_W'(-den_ff[0]) : COEFF_W'(den_ff[0]);
   assign sh_val = SH_W'(acc_ff >>> FRAC_SHIFT);

   always_comb begin
      if (sh_val > SH_W'(SAMPLE_MAX)) begin
         shy_in = SAMPLE_MAX;
      end else if (sh_val < SH_W'(SAMPLE_MIN)) begin
         shy_in = SAMPLE_MIN;
      end else begin
         shy_in = sh_val[SAMPLE_W-1:0];
      end
   end

   assign div_zero        = (den_ff[0] == '0);
   assign ovf             = (mag_ff >= (ACC_W'(d_ff) << DIV_STEPS));
   assign status.skip_div = div_zero || ovf;

   // One restoring step: shift in the next dividend bit and try the divisor.
   assign trial    = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_ge = (trial >= {1'b0, d_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.check) begin
         rem_in = mag_ff[DIV_STEPS+COEFF_W-1:DIV_STEPS];
         quo_in = mag_ff[QUO_W-1:0];
      end else if (cmd.div_step) begin
         rem_in = trial_ge ? COEFF_W'(trial - {1'b0, d_ff}) : trial[COEFF_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], trial_ge};
      end
   end

   assign q_s   = sample_type'({1'b0, quo_ff});
   assign y_fin = use_div_ff ? (neg_res_ff ? -q_s : q_s) : y_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign fire            = cmd.finish && status.out_free;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= req_sample;
      end
      if (cmd.mul_en) begin
         prod_ff     <= prod_in;
         prod_sub_ff <= cmd.is_den;
      end
      acc_ff <= acc_in;
      if (cmd.mag) begin
         mag_ff     <= mag_in;
         d_ff       <= d_in;
         neg_res_ff <= acc_ff[ACC_W-1] ^ den_ff[0][COEFF_W-1];
         shy_ff     <= shy_in;
      end
      if (cmd.check) begin
         use_div_ff <= !status.skip_div;
         y_ff       <= div_zero ? shy_ff : (neg_res_ff ? SAMPLE_MIN : SAMPLE_MAX);
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (fire) begin
         rsp_sample_ff <= y_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < HIST_LEN; k++) begin
            xh_ff[k] <= '0;
            yh_ff[k] <= '0;
         end
      end else begin
         prod_valid_ff <= cmd.mul_en;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            xh_ff[0]     <= x_ff;
            yh_ff[0]     <= y_fin;
            for (int k = 1; k < HIST_LEN; k++) begin
               xh_ff[k] <= xh_ff[k-1];
               yh_ff[k] <= yh_ff[k-1];
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

>>> hw/rtl/iir_third_order_filter_top.sv
// ----------------------------------------------------------------------------
// iir_third_order_filter_top
// Direct form I IIR filter of up to third order, modeling a power converter.
// Samples arrive on req_bus as Q16.16 beats and leave on rsp_bus, one result
// beat per input beat, in order. The coefficients b0..b3 and a0..a3 (Q4.28)
// are written on csr_bus at indexes 0..7; other indexes are ignored. Write them
// only while no sample is in flight. csr_bus is always ready.
// A sample is taken only while the sequencer is idle. Its 2*NUM_TAPS-1
// products go one per cycle through a single 32x32 multiplier into a 67-bit
// accumulator; a nonzero a0 then drives a 31-step restoring divider, which is
// skipped when the quotient is known to saturate. The next input beat is taken
// once the result has moved into the output register.
// Reset restores b0 = a0 = 1.0, clears the other coefficients and both sample
// histories, and empties the output register.
// A finished result sits in the output register until rsp_bus.ready takes it;
// the block may accept and compute the next sample meanwhile and holds it in
// its final step until the output register frees up.
// ----------------------------------------------------------------------------
`include "iir_third_order_filter_top_assert.svh"

module iir_third_order_filter_top import iir3_pkg::*; #(
   parameter int NUM_TAPS = 4
) (
   input  logic              clock,
   input  logic              reset,
   iir3_req_if.sink          req_bus,
   iir3_rsp_if.source        rsp_bus,
   iir3_csr_if.sink          csr_bus
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Coefficient writes go straight into the registers, so the port never stalls.
   assign csr_bus.ready = 1'b1;

   // The sequencer owns the input handshake and steps the datapath.
   iir3_ctrl #(
      .NUM_TAPS (NUM_TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // The datapath owns the coefficients, histories and the output register.
   iir3_datapath #(
      .NUM_TAPS (NUM_TAPS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .csr_valid  (csr_bus.valid),
      .csr_index  (csr_bus.reg_index),
      .csr_wdata  (csr_bus.wdata),
      .req_sample (req_bus.actuation_sample),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_sample (rsp_bus.response_sample)
   );

   // An accepted input beat closes the input until its result is handed off.
   `IIR3_ASSERT_NEXT(a_busy_after_accept, req_bus.valid && req_bus.ready, !req_bus.ready, "input still ready after accept")

   // No new sample may be taken while the multiplier or divider is working.
   `IIR3_ASSERT_NOW(a_no_accept_in_work, dp_cmd.mul_en || dp_cmd.div_step, !req_bus.ready, "input ready during computation")

   // A capture is always followed by the first multiply step.
   `IIR3_ASSERT_NEXT(a_mac_after_capture, dp_cmd.capture, dp_cmd.mul_en, "no multiply after capture")

   // A completed result must show up as a valid output beat.
   `IIR3_ASSERT_NEXT(a_result_valid, dp_cmd.finish && dp_status.out_free, rsp_bus.valid, "result lost at hand-off")

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the third-order IIR filter
// Sends Q16.16 sample beats into the filter in bursts with random gaps. Each
// accepted beat runs through a cycle-free predictor of the direct form I
// recursion, and the expected response joins a queue. The response channel
// stalls on a rotating pattern, and every response beat is checked against
// the oldest expected value. Coefficients are reprogrammed between phases
// while the filter is idle. The run covers identity, damped, wild, zero-divisor
// and corner-value settings.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import iir3_pkg::*;

   localparam int TAP_COUNT    = 4;
   localparam int HIST_DEPTH   = TAP_COUNT - 1;
   // Random samples to send after the directed part.
   localparam int RANDOM_ITEMS = 1450;
   // Quiet cycles after the last response, a little more than the full latency.
   localparam int DRAIN_CYCLES = 2 * TAP_COUNT + 40;
   // Cycles without any accepted beat before the run is declared hung.
   localparam int STALL_LIMIT  = 2000;
   localparam int REPORT_LIMIT = 10;

   // Kinds of coefficient set used by the random phases.
   typedef enum int {
      CFG_DAMPED,
      CFG_WILD,
      CFG_NO_DIVIDE,
      CFG_CORNER
   } cfg_kind_type;

   logic clock;
   logic reset;

   iir3_req_if req_bus ();
   iir3_rsp_if rsp_bus ();
   iir3_csr_if csr_bus ();

   iir_third_order_filter_top #(
      .NUM_TAPS(TAP_COUNT)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predictor state: the coefficients as the filter holds them, and the past
   // inputs and outputs, most recent first.
   coeff_type  num_coef [COEFF_NUM];
   coeff_type  den_coef [COEFF_NUM];
   sample_type in_hist  [HIST_DEPTH];
   sample_type out_hist [HIST_DEPTH];

   // Coefficients staged for the next register load.
   coeff_type  next_num [COEFF_NUM];
   coeff_type  next_den [COEFF_NUM];

   // Samples waiting to be sent, and responses that the filter still owes.
   sample_type pending_samples [$];
   sample_type expected_responses [$];

   int          fail_count;
   int          report_count;
   int          items_sent;
   // When set, neither side idles or stalls.
   bit          free_flow;
   int          burst_left;
   int          gap_left;
   logic [15:0] ready_pattern;
   int          pattern_age;
   int          quiet_cycles;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Computes the filter's response to one input sample and advances the
   // histories. The accumulator is far wider than the seven 64-bit products
   // can ever need, so the sum is exact.
   function automatic sample_type filter_response(input sample_type x);
      logic signed [127:0] acc;
      logic signed [127:0] shifted;
      logic signed [127:0] a0_wide;
      logic [127:0]        acc_mag;
      logic [127:0]        div_mag;
      logic [127:0]        quo;
      logic [31:0]         quo_low;
      logic                neg_acc;
      logic                neg_div;
      sample_type          y;
      int                  k;
      acc = num_coef[0] * x;
      for (k = 1; k < TAP_COUNT; k++) begin
         acc = acc + num_coef[k] * in_hist[k-1] - den_coef[k] * out_hist[k-1];
      end
      if (den_coef[0] == 0) begin
         // Without a divisor the Q20.44 sum is scaled back by a floor shift.
         shifted = acc >>> FRAC_SHIFT;
         if (shifted > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
         end else if (shifted < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
         end else begin
            y = shifted[31:0];
         end
      end else begin
         // Divide magnitudes so that the quotient truncates toward zero.
         a0_wide = den_coef[0];
         neg_acc = acc[127];
         neg_div = a0_wide[127];
         acc_mag = neg_acc ? -acc : acc;
         div_mag = neg_div ? -a0_wide : a0_wide;
         quo     = acc_mag / div_mag;
         if (quo >= 128'h8000_0000) begin
            y = (neg_acc != neg_div) ? SAMPLE_MIN : SAMPLE_MAX;
         end else begin
            quo_low = quo[31:0];
            y = (neg_acc != neg_div) ? -quo_low : quo_low;
         end
      end
      for (k = HIST_DEPTH - 1; k > 0; k--) begin
         in_hist[k]  = in_hist[k-1];
         out_hist[k] = out_hist[k-1];
      end
      in_hist[0]  = x;
      out_hist[0] = y;
      return y;
   endfunction

   // Uniform value in [-span, span].
   function automatic coeff_type spread(input int span);
      return coeff_type'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // Writes one register and mirrors it in the predictor once the beat is
   // taken. Valid stays high so that back-to-back writes need no gap; the
   // caller lowers it.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input coeff_type value);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= index;
      csr_bus.wdata     <= value;
      do @(posedge clock); while (!csr_bus.ready);
      if (index < DEN_COEFF_BASE) begin
         num_coef[index - NUM_COEFF_BASE] = value;
      end else if (index < CSR_COUNT) begin
         den_coef[index - DEN_COEFF_BASE] = value;
      end
   endtask

   // Loads the staged coefficients selected by mask (bits 0-3 numerator,
   // bits 4-7 denominator) and, if asked, a write to an unused index.
   task automatic commit_coeffs(input logic [7:0] mask, input bit stray);
      int k;
      for (k = 0; k < COEFF_NUM; k++) begin
         if (mask[k]) begin
            write_reg(NUM_COEFF_BASE + CSR_INDEX_W'(k), next_num[k]);
         end
         if (mask[COEFF_NUM + k]) begin
            write_reg(DEN_COEFF_BASE + CSR_INDEX_W'(k), next_den[k]);
         end
      end
      if (stray) begin
         write_reg(CSR_COUNT + CSR_INDEX_W'($urandom_range(0, 7)), $urandom);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // Returns at a clock edge once every sample has been sent and answered.
   task automatic wait_idle();
      while (pending_samples.size() != 0 || expected_responses.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Sample driver. It works in bursts: after a burst of accepted beats it
   // rests for a random gap. A presented beat is held until it is taken.
   always @(posedge clock) begin
      logic       fire;
      logic       next_valid;
      sample_type dropped;
      fire = req_bus.valid && req_bus.ready;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         next_valid = req_bus.valid;
         if (fire) begin
            expected_responses.push_back(filter_response(req_bus.actuation_sample));
            dropped    = pending_samples.pop_front();
            next_valid = 1'b0;
            if (!free_flow) begin
               if (burst_left > 0) begin
                  burst_left--;
               end
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  // Mostly short gaps; some long enough to span a whole divide.
                  gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 6);
               end
            end
         end
         if (!next_valid) begin
            if (gap_left > 0 && !free_flow) begin
               gap_left--;
            end else if (pending_samples.size() > 0) begin
               next_valid = 1'b1;
               req_bus.actuation_sample <= pending_samples[0];
            end
         end
         req_bus.valid <= next_valid;
      end
   end

   // Response monitor. Each response beat is compared with the oldest expected
   // value. Ready follows a 16-bit pattern that rotates every cycle and is
   // replaced whenever pattern_age wraps; a single-bit pattern gives long stalls.
   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_pattern = 16'hFFFF;
         pattern_age   = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_responses.size() == 0) begin
               fail_count++;
               if (report_count < REPORT_LIMIT) begin
                  report_count++;
                  $display("unexpected response beat: got %h", rsp_bus.response_sample);
               end
            end else begin
               want = expected_responses.pop_front();
               if (rsp_bus.response_sample !== want) begin
                  fail_count++;
                  if (report_count < REPORT_LIMIT) begin
                     report_count++;
                     $display("response_sample mismatch: expected %h, got %h",
                              want, rsp_bus.response_sample);
                  end
               end
            end
         end
         pattern_age++;
         if (pattern_age == 32) begin
            pattern_age   = 0;
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'h0001
                                                        : 16'($urandom_range(1, 16'hFFFF));
         end else begin
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
         end
         rsp_bus.ready <= free_flow || ready_pattern[0];
      end
   end

   // Watchdog. Any accepted beat on any channel restarts the count.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
                   || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   // Stimulus. Every sample is queued here and sent by the driver. The
   // coefficients only change once the filter has answered everything.
   initial begin
      int           k;
      int           phase_no;
      int           phase_len;
      int           pause_at;
      int           a0_mag;
      cfg_kind_type kind;
      logic [7:0]   mask;
      bit           stray;
      sample_type   x;
      sample_type   last_x;

      reset                    = 1'b1;
      req_bus.valid            = 1'b0;
      req_bus.actuation_sample = '0;
      rsp_bus.ready            = 1'b0;
      csr_bus.valid            = 1'b0;
      csr_bus.reg_index        = '0;
      csr_bus.wdata            = '0;
      free_flow                = 1'b0;
      fail_count               = 0;
      report_count             = 0;
      items_sent               = 0;
      last_x                   = '0;

      // The predictor starts from the reset state: unit b0 and a0, the rest
      // cleared, empty histories.
      for (k = 0; k < COEFF_NUM; k++) begin
         num_coef[k] = '0;
         den_coef[k] = '0;
      end
      num_coef[0] = COEFF_ONE;
      den_coef[0] = COEFF_ONE;
      for (k = 0; k < HIST_DEPTH; k++) begin
         in_hist[k]  = '0;
         out_hist[k] = '0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients form an identity filter, so each response equals
      // its input. The sample extremes and alternating bit patterns go first.
      pending_samples.push_back(sample_type'(0));
      pending_samples.push_back(sample_type'(1));
      pending_samples.push_back(sample_type'(-1));
      pending_samples.push_back(SAMPLE_MAX);
      pending_samples.push_back(SAMPLE_MIN);
      pending_samples.push_back(sample_type'(32'h5555_5555));
      pending_samples.push_back(sample_type'(32'hAAAA_AAAA));
      wait_idle();

      // Every other register at an extreme, with a zero divisor so the sum is only
      // shifted, and a write to an unused index that must change nothing.
      // The responses saturate both ways.
      next_num[0] = SAMPLE_MAX;
      next_num[1] = SAMPLE_MIN;
      next_num[2] = SAMPLE_MAX;
      next_num[3] = SAMPLE_MIN;
      next_den[0] = '0;
      next_den[1] = SAMPLE_MIN;
      next_den[2] = SAMPLE_MAX;
      next_den[3] = SAMPLE_MIN;
      commit_coeffs(8'hFF, 1'b1);
      pending_samples.push_back(SAMPLE_MAX);
      pending_samples.push_back(SAMPLE_MIN);
      pending_samples.push_back(sample_type'(-1));
      pending_samples.push_back(sample_type'(0));
      pending_samples.push_back(sample_type'(1));
      wait_idle();

      // Most negative divisor: the quotient truncates toward zero and its
      // sign flips.
      for (k = 1; k < COEFF_NUM; k++) begin
         next_num[k] = '0;
         next_den[k] = '0;
      end
      next_num[0] = SAMPLE_MAX;
      next_den[0] = SAMPLE_MIN;
      commit_coeffs(8'hFF, 1'b0);
      pending_samples.push_back(SAMPLE_MAX);
      pending_samples.push_back(SAMPLE_MIN);
      pending_samples.push_back(sample_type'(1));
      pending_samples.push_back(sample_type'(-1));
      wait_idle();

      // Divisor of minus one unit in the last place: the quotient is the whole
      // sum, with its sign flipped.
      next_den[0] = coeff_type'(-1);
      commit_coeffs(8'h10, 1'b0);
      pending_samples.push_back(sample_type'(0));
      pending_samples.push_back(sample_type'(1));
      pending_samples.push_back(sample_type'(-1));
      wait_idle();

      // Zero divisor with the smallest b0: the shift rounds toward minus
      // infinity, which shows on negative inputs.
      next_num[0] = coeff_type'(1);
      next_den[0] = '0;
      commit_coeffs(8'h11, 1'b0);
      pending_samples.push_back(sample_type'(-1));
      pending_samples.push_back(sample_type'(1));
      pending_samples.push_back(sample_type'(-5));
      pending_samples.push_back(SAMPLE_MIN);
      wait_idle();

      // Random phases. Damped sets keep the feedback gain below one so that
      // the recursion runs long without saturating. Wild and corner sets push
      // the divider and the saturation logic. Some phases only reload part of
      // the registers.
      phase_no = 0;
      while (items_sent < RANDOM_ITEMS) begin
         k = $urandom_range(0, 19);
         kind = (k < 10) ? CFG_DAMPED : (k < 13) ? CFG_WILD
              : (k < 17) ? CFG_NO_DIVIDE : CFG_CORNER;
         a0_mag = $urandom_range(1 << 27, 1 << 29);
         for (k = 0; k < COEFF_NUM; k++) begin
            case (kind)
               CFG_DAMPED: begin
                  next_num[k] = spread(1 << 28);
                  next_den[k] = (k == 0) ? ($urandom_range(0, 1) ? a0_mag : -a0_mag)
                                         : spread(a0_mag / 4);
               end
               CFG_WILD: begin
                  next_num[k] = $urandom;
                  next_den[k] = $urandom;
               end
               CFG_NO_DIVIDE: begin
                  next_num[k] = spread(1 << 28);
                  next_den[k] = (k == 0) ? coeff_type'(0) : spread(1 << 26);
               end
               default: begin
                  case ($urandom_range(0, 6))
                     0:       next_num[k] = SAMPLE_MAX;
                     1:       next_num[k] = SAMPLE_MIN;
                     2:       next_num[k] = '0;
                     3:       next_num[k] = coeff_type'(1);
                     4:       next_num[k] = coeff_type'(-1);
                     5:       next_num[k] = COEFF_ONE;
                     default: next_num[k] = -COEFF_ONE;
                  endcase
                  case ($urandom_range(0, 6))
                     0:       next_den[k] = SAMPLE_MAX;
                     1:       next_den[k] = SAMPLE_MIN;
                     2:       next_den[k] = '0;
                     3:       next_den[k] = coeff_type'(1);
                     4:       next_den[k] = coeff_type'(-1);
                     5:       next_den[k] = COEFF_ONE;
                     default: next_den[k] = -COEFF_ONE;
                  endcase
               end
            endcase
         end
         mask  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'hFF;
         stray = ($urandom_range(0, 3) == 0);
         commit_coeffs(mask, stray);

         free_flow = ($urandom_range(0, 4) == 0);
         phase_len = (kind == CFG_WILD || kind == CFG_CORNER) ? $urandom_range(10, 40)
                                                              : $urandom_range(20, 100);
         // In the first phase, and now and then later, the sender stops
         // halfway until the filter has answered everything.
         pause_at = (phase_no == 0 || $urandom_range(0, 3) == 0) ? phase_len / 2 : -1;
         for (k = 0; k < phase_len; k++) begin
            if (k == pause_at) begin
               wait_idle();
            end
            case ($urandom_range(0, 11))
               0:          x = SAMPLE_MAX;
               1:          x = SAMPLE_MIN;
               2:          x = int'($urandom_range(0, 2)) - 1;
               3, 4, 5, 6: x = int'($urandom_range(0, 1 << 21)) - (1 << 20);
               // A repeated sample builds a step for the recursion to follow.
               7, 8:       x = last_x;
               default:    x = $urandom;
            endcase
            last_x = x;
            pending_samples.push_back(x);
            items_sent++;
         end
         wait_idle();
         phase_no++;
      end

      free_flow = 1'b0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_responses.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/iir3_pkg.sv
hw/rtl/iir3_interfaces.sv
hw/rtl/iir3_ctrl.sv
hw/rtl/iir3_datapath.sv
hw/rtl/iir_third_order_filter_top.sv
tb/tb_top.sv
